>>> rtl/core/frame_gain_ramp_curve_unit_defines.svh
// Assertion macros shared by the frame gain ramp curve RTL.
`ifndef FRAME_GAIN_RAMP_CURVE_UNIT_DEFINES_SVH
`define FRAME_GAIN_RAMP_CURVE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define FGRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fgrc assertion failed");
// Checked on every clock edge, reset included.
`define FGRC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("fgrc assertion failed");
`else
`define FGRC_ASSERT(lbl, prop)
`define FGRC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/core/fgrc_pkg.sv
// Types and constants of the frame gain ramp curve unit.
package fgrc_pkg;

  localparam logic [13:0] GAIN_ONE = 14'd10000;

  // Reciprocal of the unity gain, ceil(2^45 / 10000), split into 16-bit halves.
  // A 32-bit value times it, shifted right by 45, is the exact quotient.
  localparam logic [15:0] RECIP_HI = 16'hD1B7;
  localparam logic [15:0] RECIP_LO = 16'h1759;

  localparam logic [1:0]  MODE_SEED  = 2'd0;
  localparam logic [1:0]  MODE_PLAY  = 2'd3;
  localparam logic [15:0] SYNC_SEED  = 16'd1;
  localparam logic [15:0] SYNC_STEP  = 16'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] sync_count;
    logic [15:0] luma_accel;
    logic [15:0] luma_target;
    logic [15:0] luma_step;
    logic [15:0] chroma_accel;
    logic [15:0] chroma_target;
    logic [15:0] chroma_step;
    logic [7:0]  live_bright_byte;
    logic [7:0]  live_sat_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] bright_gain;
    logic [7:0] sat_gain;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_T_SEED,
    ST_T_UPD,
    ST_T_M1,
    ST_T_M2,
    ST_T_DIVW,
    ST_T_OUT,
    ST_T_OUTW,
    ST_P_TU,
    ST_P_TUW,
    ST_P_D2,
    ST_P_D2W,
    ST_P_UPD,
    ST_P_FIN,
    ST_NEXT,
    ST_DONE
  } state_e;

endpackage

>>> rtl/core/fgrc_div.sv
// Divider of a 32-bit value by the unity gain constant through reciprocal multiplication.
module fgrc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import fgrc_pkg::*;

  logic [31:0] x_q, x_d;
  logic [31:0] lo_q, lo_d;
  logic [31:0] quot_q, quot_d;
  logic        lo_pend_q, lo_pend_d;
  logic        hi_pend_q, hi_pend_d;
  logic        done_q, done_d;
  logic [15:0] mul_b;
  logic [47:0] prod;
  logic [48:0] sum;

  // One 32 by 16 multiplier takes the low half of the reciprocal first, then the high half.
  assign mul_b = hi_pend_q ? RECIP_HI : RECIP_LO;
  assign prod  = {16'd0, x_q} * {32'd0, mul_b};
  assign sum   = {1'b0, prod} + {17'd0, lo_q};

  always_comb begin
    x_d       = x_q;
    lo_d      = lo_q;
    quot_d    = quot_q;
    lo_pend_d = 1'b0;
    hi_pend_d = 1'b0;
    done_d    = 1'b0;
    if (start_i) begin
      x_d       = dividend_i;
      lo_pend_d = 1'b1;
    end else if (lo_pend_q) begin
      lo_d      = prod[47:16];
      hi_pend_d = 1'b1;
    end else if (hi_pend_q) begin
      quot_d = {12'd0, sum[48:29]};
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_pend_q <= 1'b0;
      hi_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      lo_pend_q <= lo_pend_d;
      hi_pend_q <= hi_pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> rtl/core/frame_gain_ramp_curve_unit.sv
// Frame gain ramp curve unit: steps luma and chroma gain ramps once per sync.
// The reciprocal divider serves the channels in turn: each channel uses it twice in play mode
// and for a trick-mode extrapolation, and once for a trick-mode seed or step.
// The output register lets the next item start while a result waits. Reset (asynchronous,
// active low) sets all ramp gains to unity and all unit values to one.
module frame_gain_ramp_curve_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  fgrc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output fgrc_pkg::out_t out_data_o
);
  import fgrc_pkg::*;

`include "frame_gain_ramp_curve_unit_defines.svh"

  // The item is held here for the whole computation.
  in_t         in_q;
  state_e      state_q, state_d;
  logic        ch_q, ch_d;

  // Ramp state, one entry per channel: 0 is luma, 1 is chroma.
  logic [31:0] now_q [2];
  logic [31:0] now_d [2];
  logic [31:0] b2_q  [2];
  logic [31:0] b2_d  [2];
  logic [31:0] b1_q  [2];
  logic [31:0] b1_d  [2];
  // Play-mode whole units: 0 current, 1 two syncs back, 2 one sync back.
  logic [15:0] u_q   [2][3];
  logic [15:0] u_d   [2][3];

  // Scratch registers of the sequencer.
  logic [31:0] mul_q, mul_d;
  logic [2:0]  tu_q, tu_d;
  logic [2:0]  d2_q, d2_d;
  logic [15:0] cur_q, cur_d;
  logic [7:0]  byte_q [2];
  logic [7:0]  byte_d [2];

  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  // The shared multiplier: at most 32 by 16 bits, product kept modulo 2^32.
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_full;
  logic [31:0] mul_p;

  // The shared divider by the unity constant.
  logic        div_start;
  logic [31:0] div_in;
  logic        div_done;
  logic [31:0] div_quot;

  // Channel-selected operands.
  logic [15:0] tar;
  logic [31:0] tar32;
  logic [15:0] stp;
  logic [15:0] acc;
  logic [8:0]  seed_fac;
  logic [15:0] v1, v2;
  logic [31:0] diff;
  logic [15:0] p1, p2;
  logic [15:0] q16;
  logic [15:0] cl16;
  logic [31:0] new_now;
  logic [15:0] u0n;
  logic        hit;
  logic        is_seed, is_step;

  fgrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[31:0];

  always_comb begin
    tar   = ch_q ? in_q.chroma_target : in_q.luma_target;
    stp   = ch_q ? in_q.chroma_step   : in_q.luma_step;
    acc   = ch_q ? in_q.chroma_accel  : in_q.luma_accel;
    tar32 = {16'd0, tar};
    // A zero brightness byte seeds luma at unity.
    if (ch_q) begin
      seed_fac = {1'b0, in_q.live_sat_byte};
    end else if (in_q.live_bright_byte == 8'd0) begin
      seed_fac = 9'd128;
    end else begin
      seed_fac = 9'(9'd256 - {1'b0, in_q.live_bright_byte});
    end
    v1      = b1_q[ch_q][15:0];
    v2      = b2_q[ch_q][15:0];
    diff    = 32'({16'd0, v2} - {16'd0, v1});
    p1      = u_q[ch_q][2];
    p2      = u_q[ch_q][1];
    is_seed = (in_q.sync_count == SYNC_SEED);
    is_step = (in_q.sync_count == SYNC_STEP);
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    now_d       = now_q;
    b2_d        = b2_q;
    b1_d        = b1_q;
    u_d         = u_q;
    mul_d       = mul_q;
    tu_d        = tu_q;
    d2_d        = d2_q;
    cur_d       = cur_q;
    byte_d      = byte_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_in      = '0;
    q16         = div_quot[15:0];
    cl16        = '0;
    new_now     = '0;
    u0n         = '0;
    hit         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ch_d    = 1'b0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = (in_q.mode == MODE_PLAY) ? ST_P_TU : ST_T_SEED;
      end
      // Trick modes.
      ST_T_SEED: begin
        mul_a = {23'd0, seed_fac};
        mul_b = {2'd0, GAIN_ONE};
        if (in_q.mode == MODE_SEED && is_seed) begin
          now_d[ch_q] = {7'd0, mul_p[31:7]};
        end
        state_d = ST_T_UPD;
      end
      ST_T_UPD: begin
        if (is_seed) begin
          b2_d[ch_q] = now_q[ch_q];
          b1_d[ch_q] = now_q[ch_q];
          state_d    = ST_T_OUT;
        end else if (is_step) begin
          if (b2_q[ch_q] > tar32) begin
            new_now     = 32'(b2_q[ch_q] - {16'd0, stp});
            b1_d[ch_q]  = new_now;
            now_d[ch_q] = (new_now > tar32) ? new_now : tar32;
          end
          state_d = ST_T_OUT;
        end else begin
          state_d = ST_T_M1;
        end
      end
      ST_T_M1: begin
        mul_a   = {16'd0, v1};
        mul_b   = {2'd0, GAIN_ONE};
        mul_d   = mul_p;
        state_d = ST_T_M2;
      end
      ST_T_M2: begin
        mul_a     = diff;
        mul_b     = acc;
        div_start = 1'b1;
        div_in    = 32'(mul_q - mul_p);
        state_d   = ST_T_DIVW;
      end
      ST_T_DIVW: begin
        if (div_done) begin
          // Clamp at the target once the ramp would cross it.
          cl16        = (v1 > tar && q16 <= tar) ? tar : q16;
          new_now     = {16'd0, cl16};
          now_d[ch_q] = new_now;
          b1_d[ch_q]  = new_now;
          b2_d[ch_q]  = (new_now <= tar32) ? new_now : b1_q[ch_q];
          state_d     = ST_T_OUT;
        end
      end
      ST_T_OUT: begin
        div_start = 1'b1;
        div_in    = {now_q[ch_q][24:0], 7'd0};
        state_d   = ST_T_OUTW;
      end
      ST_T_OUTW: begin
        if (div_done) begin
          byte_d[ch_q] = div_quot[7:0];
          state_d      = ST_NEXT;
        end
      end
      // Play mode.
      ST_P_TU: begin
        div_start = 1'b1;
        div_in    = tar32;
        state_d   = ST_P_TUW;
      end
      ST_P_TUW: begin
        if (div_done) begin
          tu_d    = div_quot[2:0];
          state_d = ST_P_D2;
        end
      end
      ST_P_D2: begin
        div_start = 1'b1;
        if (is_seed) begin
          div_in = {16'd0, now_q[ch_q][15:0]};
        end else if (is_step) begin
          div_in = {16'd0, stp};
        end else begin
          div_in = {16'd0, acc};
        end
        state_d = ST_P_D2W;
      end
      ST_P_D2W: begin
        if (div_done) begin
          d2_d    = div_quot[2:0];
          state_d = ST_P_UPD;
        end
      end
      ST_P_UPD: begin
        if (is_seed) begin
          u_d[ch_q][0] = {13'd0, d2_q};
          u_d[ch_q][1] = {13'd0, d2_q};
          u_d[ch_q][2] = {13'd0, d2_q};
          state_d      = ST_NEXT;
        end else if (is_step) begin
          cur_d   = 16'(p2 + {13'd0, d2_q});
          state_d = ST_P_FIN;
        end else begin
          mul_a   = {16'd0, 16'(p1 - p2)};
          mul_b   = {13'd0, d2_q};
          cur_d   = 16'(p1 + mul_p[15:0]);
          state_d = ST_P_FIN;
        end
      end
      ST_P_FIN: begin
        mul_b = {2'd0, GAIN_ONE};
        if (is_step) begin
          if (p2 < {13'd0, tu_q}) begin
            u0n          = (cur_q < {13'd0, tu_q}) ? cur_q : {13'd0, tu_q};
            u_d[ch_q][2] = cur_q;
            u_d[ch_q][0] = u0n;
            mul_a        = {16'd0, u0n};
            now_d[ch_q]  = mul_p;
          end
        end else begin
          hit   = (cur_q > {13'd0, tu_q}) && (p1 < {13'd0, tu_q});
          mul_a = {16'd0, cur_q};
          if (hit) begin
            u_d[ch_q][0] = {13'd0, tu_q};
            u_d[ch_q][1] = {13'd0, tu_q};
            u_d[ch_q][2] = {13'd0, tu_q};
            now_d[ch_q]  = tar32;
          end else begin
            u_d[ch_q][0] = cur_q;
            u_d[ch_q][1] = p1;
            u_d[ch_q][2] = cur_q;
            now_d[ch_q]  = mul_p;
          end
        end
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (!ch_q) begin
          ch_d    = 1'b1;
          state_d = ST_START;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (in_q.mode == MODE_PLAY) begin
            out_d.bright_gain = {u_q[0][0][0], 7'd0};
            out_d.sat_gain    = {u_q[1][0][0], 7'd0};
          end else begin
            out_d.bright_gain = byte_q[0];
            out_d.sat_gain    = byte_q[1];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        now_q[c] <= {18'd0, GAIN_ONE};
        b2_q[c]  <= {18'd0, GAIN_ONE};
        b1_q[c]  <= {18'd0, GAIN_ONE};
        for (int k = 0; k < 3; k++) begin
          u_q[c][k] <= 16'd1;
        end
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      now_q       <= now_d;
      b2_q        <= b2_d;
      b1_q        <= b1_d;
      u_q         <= u_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    mul_q  <= mul_d;
    tu_q   <= tu_d;
    d2_q   <= d2_d;
    cur_q  <= cur_d;
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted item keeps the block busy on the next cycle.
  `FGRC_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // A new result is only loaded from the final sequencer state.
  `FGRC_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  // The divider finishes only while the sequencer waits on it.
  `FGRC_ASSERT(a_div_done_waited,
      div_done |-> (state_q == ST_T_DIVW || state_q == ST_T_OUTW ||
                    state_q == ST_P_TUW || state_q == ST_P_D2W))

endmodule
